// ----- rtl/prime_modular_arith_unit_assert.svh -----
// assertion macros for the prime modular arithmetic unit
`ifndef PRIME_MODULAR_ARITH_UNIT_ASSERT_SVH
`define PRIME_MODULAR_ARITH_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define PMA_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define PMA_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define PMA_ASSERT_NOW(lbl, ant, cons, msg)
`define PMA_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

// ----- rtl/pma_pkg.sv -----
`default_nettype none
package pma_pkg;
    localparam int MODULUS_DEF = 998244353;
    localparam int EXP_W = 63;
    localparam int RES_W = 30;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_POW = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_DIV = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic {
        U_MUL,
        U_DIV
    } t_umode;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [RES_W-1:0] operand_a;
        logic [RES_W-1:0] operand_b;
        logic [EXP_W-1:0] exponent;
    } t_req;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic [1:0]       status;
    } t_rsp;
endpackage
`default_nettype wire

// ----- rtl/prime_modular_arith_unit.sv -----
`default_nettype none
// prime modular arithmetic unit
// command channel: drive i_req and raise start; the request transfers at the
// clock edge where start is high and busy is low. busy stays high until the
// result cycle (it stays low for cases answered from idle), so one request is worked on at a time.
// result channel: o_rsp is shown for exactly one cycle with o_valid high;
// there is no back-pressure, the receiver must take it in that cycle.
// add, subtract, out-of-range and zero-inverse cases are answered straight
// from idle. the rest run on the serial unit, with W the bit width of the
// modulus (30 by default): multiply is one serial multiply; power takes a
// multiply and a square for each set exponent bit and a square for each
// clear bit below the highest set bit (the exponent bits bound the time);
// inverse takes a divide and a multiply for each reduction step until the
// residue falls to one, and divide adds one more multiply.
// busy drops in the result cycle, so the next request can transfer there.
// multiply, power, inverse and divide run through one serial unit (one
// modulus bit per cycle). synchronous reset returns the sequencer to idle
// and drops o_valid; a request can transfer in the first cycle after reset.
`include "prime_modular_arith_unit_assert.svh"
module prime_modular_arith_unit #(
    parameter int MODULUS = pma_pkg::MODULUS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    input  pma_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output pma_pkg::t_rsp o_rsp
);
    localparam int W = $clog2(longint'(MODULUS) + 1);
    localparam logic [W-1:0] MOD_W  = W'(MODULUS);
    localparam logic [31:0]  MOD_32 = 32'(MODULUS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_POW_CHK,
        S_POW_A,
        S_POW_S,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_MUL,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic                      r_valid;
    logic [W-1:0]              r_res;
    logic [1:0]                r_st;
    logic [W-1:0]              r_acc;
    logic [W-1:0]              r_cur;
    logic [W-1:0]              r_t;
    logic [W-1:0]              r_a;
    logic                      r_div;
    logic [pma_pkg::EXP_W-1:0] r_exp;
    // serial unit command
    logic                      r_u_start;
    pma_pkg::t_umode           r_u_mode;
    logic [W-1:0]              r_u_x;
    logic [W-1:0]              r_u_y;

    logic         u_done;
    logic [W-1:0] u_q;
    logic [W-1:0] u_r;

    logic         accept;
    logic         uses_b;
    logic         bad;
    logic [W-1:0] a_w;
    logic [W-1:0] b_w;
    logic [W:0]   sum;
    logic [W-1:0] add_res;
    logic [W-1:0] sub_res;
    logic [31:0]  res_ext;

    pma_serial_unit #(
        .MODULUS (MODULUS)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_u_start),
        .i_mode  (r_u_mode),
        .i_x     (r_u_x),
        .i_y     (r_u_y),
        .o_done  (u_done),
        .o_q     (u_q),
        .o_r     (u_r)
    );

    assign accept = start && !busy;
    assign a_w    = W'(i_req.operand_a);
    assign b_w    = W'(i_req.operand_b);

    // range check and the add and subtract results
    always_comb begin
        case (i_req.req_type)
            pma_pkg::OP_ADD, pma_pkg::OP_SUB, pma_pkg::OP_MUL, pma_pkg::OP_DIV: uses_b = 1'b1;
            default: uses_b = 1'b0;
        endcase
        bad = (i_req.req_type > pma_pkg::OP_DIV)
            || (32'(i_req.operand_a) >= MOD_32)
            || (uses_b && (32'(i_req.operand_b) >= MOD_32));
        sum     = {1'b0, a_w} + {1'b0, b_w};
        add_res = (sum >= {1'b0, MOD_W}) ? W'(sum - {1'b0, MOD_W}) : W'(sum);
        sub_res = (a_w >= b_w) ? (a_w - b_w) : (a_w + (MOD_W - b_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_u_start <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_u_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a   <= a_w;
                        r_acc <= W'(1);
                        if (bad) begin
                            r_res   <= '0;
                            r_st    <= pma_pkg::ST_RANGE;
                            r_valid <= 1'b1;
                        end else begin
                            unique case (i_req.req_type)
                                pma_pkg::OP_ADD: begin
                                    r_res   <= add_res;
                                    r_st    <= pma_pkg::ST_OK;
                                    r_valid <= 1'b1;
                                end
                                pma_pkg::OP_SUB: begin
                                    r_res   <= sub_res;
                                    r_st    <= pma_pkg::ST_OK;
                                    r_valid <= 1'b1;
                                end
                                pma_pkg::OP_MUL: begin
                                    r_u_start <= 1'b1;
                                    r_u_mode  <= pma_pkg::U_MUL;
                                    r_u_x     <= a_w;
                                    r_u_y     <= b_w;
                                    r_state   <= S_MUL;
                                end
                                pma_pkg::OP_POW: begin
                                    r_cur   <= a_w;
                                    r_exp   <= i_req.exponent;
                                    r_state <= S_POW_CHK;
                                end
                                default: begin
                                    // inverse of a, or divide by b
                                    r_div <= (i_req.req_type == pma_pkg::OP_DIV);
                                    r_t   <= (i_req.req_type == pma_pkg::OP_DIV) ? b_w : a_w;
                                    if (((i_req.req_type == pma_pkg::OP_DIV) ? b_w : a_w) == '0) begin
                                        r_res   <= '0;
                                        r_st    <= pma_pkg::ST_ZERO;
                                        r_valid <= 1'b1;
                                    end else begin
                                        r_state <= S_INV_CHK;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_MUL, S_FIN: begin
                    if (u_done) begin
                        r_res   <= u_r;
                        r_st    <= pma_pkg::ST_OK;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_POW_CHK: begin
                    // square-and-multiply, low exponent bit first
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_st    <= pma_pkg::ST_OK;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_exp[0]) begin
                        r_u_start <= 1'b1;
                        r_u_mode  <= pma_pkg::U_MUL;
                        r_u_x     <= r_acc;
                        r_u_y     <= r_cur;
                        r_state   <= S_POW_A;
                    end else begin
                        r_u_start <= 1'b1;
                        r_u_mode  <= pma_pkg::U_MUL;
                        r_u_x     <= r_cur;
                        r_u_y     <= r_cur;
                        r_state   <= S_POW_S;
                    end
                end
                S_POW_A: begin
                    if (u_done) begin
                        r_acc     <= u_r;
                        r_u_start <= 1'b1;
                        r_u_mode  <= pma_pkg::U_MUL;
                        r_u_x     <= r_cur;
                        r_u_y     <= r_cur;
                        r_state   <= S_POW_S;
                    end
                end
                S_POW_S: begin
                    if (u_done) begin
                        r_cur   <= u_r;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_POW_CHK;
                    end
                end
                S_INV_CHK: begin
                    if (r_t == W'(1)) begin
                        if (r_div) begin
                            r_u_start <= 1'b1;
                            r_u_mode  <= pma_pkg::U_MUL;
                            r_u_x     <= r_a;
                            r_u_y     <= r_acc;
                            r_state   <= S_FIN;
                        end else begin
                            r_res   <= r_acc;
                            r_st    <= pma_pkg::ST_OK;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_u_start <= 1'b1;
                        r_u_mode  <= pma_pkg::U_DIV;
                        r_u_x     <= r_t;
                        r_u_y     <= '0;
                        r_state   <= S_INV_DIV;
                    end
                end
                S_INV_DIV: begin
                    // quotient z gives factor (m - z), remainder is the next residue
                    if (u_done) begin
                        r_t       <= u_r;
                        r_u_start <= 1'b1;
                        r_u_mode  <= pma_pkg::U_MUL;
                        r_u_x     <= r_acc;
                        r_u_y     <= MOD_W - u_q;
                        r_state   <= S_INV_MUL;
                    end
                end
                S_INV_MUL: begin
                    if (u_done) begin
                        r_acc <= u_r;
                        if (r_t == '0) begin
                            // not invertible, only with a composite modulus
                            r_res   <= '0;
                            r_st    <= pma_pkg::ST_ZERO;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_INV_CHK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign res_ext        = 32'(r_res);
    assign o_rsp.result   = res_ext[pma_pkg::RES_W-1:0];
    assign o_rsp.status   = r_st;

    `PMA_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result shown while busy")
    `PMA_ASSERT_NEXT(a_accept_progress, accept, busy || o_valid, "transfer dropped")
    `PMA_ASSERT_NOW(a_err_zero, o_valid && (o_rsp.status != pma_pkg::ST_OK),
        o_rsp.result == '0, "error result not zero")
endmodule
`default_nettype wire

// ----- rtl/pma_serial_unit.sv -----
`default_nettype none
// bit-serial modular multiply and restoring divide of the modulus
module pma_serial_unit #(
    parameter int MODULUS = pma_pkg::MODULUS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  pma_pkg::t_umode       i_mode,
    input  wire [$clog2(longint'(MODULUS)+1)-1:0] i_x,
    input  wire [$clog2(longint'(MODULUS)+1)-1:0] i_y,
    output logic                  o_done,
    output logic [$clog2(longint'(MODULUS)+1)-1:0] o_q,
    output logic [$clog2(longint'(MODULUS)+1)-1:0] o_r
);
    localparam int W  = $clog2(longint'(MODULUS) + 1);
    localparam int CW = $clog2(W);
    localparam logic [W-1:0]   MOD_W  = W'(MODULUS);
    localparam logic [W+1:0]   MOD_1  = (W+2)'(MODULUS);
    localparam logic [W+1:0]   MOD_2  = (W+2)'(2 * longint'(MODULUS));

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    pma_pkg::t_umode r_mode;
    logic [W-1:0]    r_x;
    logic [W-1:0]    r_y;
    logic [W-1:0]    r_acc;
    logic [W-1:0]    r_q;

    logic [W+1:0] mul_s;
    logic [W-1:0] mul_n;
    logic [W:0]   div_rem;
    logic         div_ge;
    logic [W-1:0] div_n;

    // multiply: acc = 2*acc + bit*x, then fold back below the modulus
    always_comb begin
        mul_s = {1'b0, r_acc, 1'b0} + (r_y[r_cnt] ? {2'b0, r_x} : '0);
        if (mul_s >= MOD_2) begin
            mul_n = W'(mul_s - MOD_2);
        end else if (mul_s >= MOD_1) begin
            mul_n = W'(mul_s - MOD_1);
        end else begin
            mul_n = W'(mul_s);
        end
    end

    // divide: shift in next modulus bit, subtract divisor where it fits
    always_comb begin
        div_rem = {r_acc, MOD_W[r_cnt]};
        div_ge  = (div_rem >= {1'b0, r_x});
        div_n   = div_ge ? W'(div_rem - {1'b0, r_x}) : W'(div_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
                r_mode <= i_mode;
                r_x    <= i_x;
                r_y    <= i_y;
                r_acc  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_mode == pma_pkg::U_MUL) begin
                    r_acc <= mul_n;
                end else begin
                    r_acc <= div_n;
                    r_q   <= {r_q[W-2:0], div_ge};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_acc;
endmodule
`default_nettype wire

// ----- sim/tb_prime_modular_arith_unit.sv -----
`default_nettype none
module tb_prime_modular_arith_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pma_pkg::*;

    localparam longint unsigned MOD = longint'(MODULUS_DEF);
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // expected responses, oldest first
    t_rsp rsp_pending[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_sent[8] = '{default: 0};
    bit   idle_on = 1'b1;

    prime_modular_arith_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- residue arithmetic ----------------

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
        return (a * b) % MOD;
    endfunction

    // square-and-multiply, lsb first
    function automatic longint unsigned pow_mod(longint unsigned base, logic [62:0] e);
        longint unsigned acc;
        longint unsigned cur;
        acc = 1;
        cur = base;
        for (int k = 0; k < 63; k++) begin
            if (e[k]) acc = mul_mod(acc, cur);
            cur = mul_mod(cur, cur);
        end
        return acc;
    endfunction

    // quotient-reduction inverse; returns 0 when the value has no inverse
    function automatic bit inv_mod(longint unsigned v, output longint unsigned r);
        longint unsigned t;
        longint unsigned acc;
        longint unsigned z;
        r = 0;
        t = v;
        acc = 1;
        if (t == 0) return 1'b0;
        while (t != 1) begin
            z = MOD / t;
            acc = mul_mod(acc, MOD - z);
            t = MOD - t * z;
            if (t == 0) return 1'b0;
        end
        r = acc;
        return 1'b1;
    endfunction

    function automatic t_rsp residue_response(t_req q);
        t_rsp p;
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        longint unsigned ib;
        bit uses_b;
        a = longint'(q.operand_a);
        b = longint'(q.operand_b);
        r = 0;
        p.status = ST_OK;
        uses_b = q.req_type inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        if (q.req_type > OP_DIV || a >= MOD || (uses_b && b >= MOD)) begin
            p.status = ST_RANGE;
        end else begin
            case (q.req_type)
                OP_ADD: r = (a + b) % MOD;
                OP_SUB: r = (a + (MOD - b)) % MOD;
                OP_MUL: r = mul_mod(a, b);
                OP_POW: r = pow_mod(a, q.exponent);
                OP_INV: begin
                    if (!inv_mod(a, r)) p.status = ST_ZERO;
                end
                default: begin
                    if (!inv_mod(b, ib)) p.status = ST_ZERO;
                    else r = mul_mod(a, ib);
                end
            endcase
        end
        if (p.status != ST_OK) r = 0;
        p.result = r[RES_W-1:0];
        return p;
    endfunction

    // ---------------- command side ----------------

    // called just after a rising edge; start stays high across back-to-back
    // transfers and only drops for an idle burst
    task automatic send_req(t_req q);
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        rsp_pending.insert(rsp_pending.size(), residue_response(q));
        n_sent[q.req_type]++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic t_req make_req(logic [2:0] op, longint unsigned a,
                                      longint unsigned b, logic [62:0] e);
        t_req q;
        q.req_type = op;
        q.operand_a = a[RES_W-1:0];
        q.operand_b = b[RES_W-1:0];
        q.exponent = e;
        return q;
    endfunction

    // residue biased towards the edges, with the odd out-of-range value
    function automatic longint unsigned pick_residue(int bad_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < bad_pct) return longint'($urandom_range(MODULUS_DEF, 30'h3FFF_FFFF));
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return MOD - 1;
            3: return MOD - 2;
            default: return longint'($urandom_range(0, MODULUS_DEF - 1));
        endcase
    endfunction

    // exponents are mostly short to keep the serial power loop quick
    function automatic logic [62:0] pick_exponent();
        logic [62:0] e;
        int len;
        e = 63'({$urandom, $urandom});
        len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(0, 16);
        return (len == 0) ? '0 : (e >> (63 - len));
    endfunction

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: unexpected result %h/%0d", $time, o_rsp.result, o_rsp.status);
                n_errors++;
            end else begin
                want = rsp_pending.pop_front();
                n_checked++;
                if (o_rsp.result !== want.result) begin
                    $display("%0t: result expected %0d actual %0d",
                             $time, want.result, o_rsp.result);
                    n_errors++;
                end
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // edges of every operation and each named special case
    task automatic test_directed();
        longint unsigned top;
        top = 64'h3FFF_FFFF;
        send_req(make_req(OP_ADD, MOD - 1, MOD - 1, '0));
        send_req(make_req(OP_ADD, 0, 0, '1));
        send_req(make_req(OP_SUB, 0, MOD - 1, '0));
        send_req(make_req(OP_SUB, 5, 5, '0));
        send_req(make_req(OP_MUL, MOD - 1, MOD - 1, '0));
        send_req(make_req(OP_MUL, 0, 12345, '0));
        send_req(make_req(OP_POW, 0, 0, '0));           // zero exponent on zero base
        send_req(make_req(OP_POW, 3, 0, '1));           // full-width exponent
        send_req(make_req(OP_POW, MOD - 1, 0, 63'd1));
        send_req(make_req(OP_POW, 2, 0, 63'(MOD - 2)));
        send_req(make_req(OP_INV, 1, 0, '0));
        send_req(make_req(OP_INV, MOD - 1, 0, '0));
        send_req(make_req(OP_INV, 0, 0, '0));           // inverse of zero
        send_req(make_req(OP_DIV, 7, 0, '0));           // divide by zero
        send_req(make_req(OP_DIV, MOD - 1, 2, '0));
        send_req(make_req(OP_ADD, MOD, 1, '0));         // operand at modulus
        send_req(make_req(OP_MUL, 1, top, '0));
        send_req(make_req(OP_POW, top, top, '1));       // b ignored, a out of range
        send_req(make_req(OP_POW, 9, top, 63'd5));      // b out of range but unused
        send_req(make_req(OP_INV, top, 0, '0));
        send_req(make_req(OP_DIV, MOD, 0, '0));         // range beats zero divisor
        send_req(make_req(OP_BAD6, 1, 1, '0));
        send_req(make_req(OP_BAD7, top, top, '1));
    endtask

    task automatic test_add_sub_mul(int n);
        for (int k = 0; k < n; k++)
            send_req(make_req(3'($urandom_range(OP_ADD, OP_MUL)), pick_residue(5),
                              pick_residue(5), 63'({$urandom, $urandom})));
    endtask

    task automatic test_power(int n);
        for (int k = 0; k < n; k++)
            send_req(make_req(OP_POW, pick_residue(5), {$urandom, $urandom},
                              pick_exponent()));
    endtask

    task automatic test_inverse_divide(int n);
        for (int k = 0; k < n; k++)
            send_req(make_req($urandom_range(0, 1) ? OP_INV : OP_DIV, pick_residue(5),
                              pick_residue(5), 63'({$urandom, $urandom})));
    endtask

    // anything goes, undefined request codes included
    task automatic test_mixed(int n);
        for (int k = 0; k < n; k++)
            send_req(make_req(3'($urandom_range(0, 7)), pick_residue(15),
                              pick_residue(15), pick_exponent()));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_add_sub_mul(350);
        test_power(300);
        test_inverse_divide(350);
        test_mixed(200);
        // final stretch back to back with no idle bursts
        idle_on = 1'b0;
        test_mixed(200);
        start <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d add, %0d sub, %0d mul, %0d pow, %0d inv, %0d div, %0d undefined",
                 n_sent[OP_ADD], n_sent[OP_SUB], n_sent[OP_MUL], n_sent[OP_POW],
                 n_sent[OP_INV], n_sent[OP_DIV], n_sent[OP_BAD6] + n_sent[OP_BAD7]);
        $display("%0d results checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && rsp_pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // generous overall limit for the long exponents and long reduction loops
    initial begin
        #1_000_000_000;
        $display("timeout with %0d results outstanding", rsp_pending.size());
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/pma_pkg.sv
rtl/pma_serial_unit.sv
rtl/prime_modular_arith_unit.sv
sim/tb_prime_modular_arith_unit.sv
